### rtl/available_item_table_picker_core_defines.svh
// Assertion macros for the available item table picker.
// Used by the top level only; no other dependencies.
`ifndef AVAILABLE_ITEM_TABLE_PICKER_CORE_DEFINES_SVH
`define AVAILABLE_ITEM_TABLE_PICKER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define AVITP_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
`define AVITP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AVITP_ASSERT_ALWAYS(lbl, expr)
`define AVITP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/avitp_pkg.sv
// Shared types and constants of the available item table picker.
// No dependencies.
`default_nettype none
package avitp_pkg;
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_W      = 20;
    localparam int REF_W       = 24;
    localparam int FRAC_W      = 16;
    localparam int REFS_W      = 32;
    localparam int SUM_W       = REF_W + CNT_W;

    localparam logic [2:0] OP_APPEND   = 3'd0;
    localparam logic [2:0] OP_DEC      = 3'd1;
    localparam logic [2:0] OP_QUERY    = 3'd2;
    localparam logic [2:0] OP_DELETE   = 3'd3;
    localparam logic [2:0] OP_TOGGLE   = 3'd4;
    localparam logic [2:0] OP_UNIFORM  = 3'd5;
    localparam logic [2:0] OP_WEIGHTED = 3'd6;
    localparam logic [2:0] OP_UNUSED   = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NO_PICK   = 2'd3;

    typedef struct packed {
        logic [2:0]        op;
        logic [NAME_W-1:0] item_name;
        logic [REF_W-1:0]  ref_count;
        logic [FRAC_W-1:0] random_fraction;
        logic [REFS_W-1:0] refs_remaining;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [NAME_W-1:0] picked_name;
        logic [REF_W-1:0]  count_out;
    } t_rsp;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [REF_W-1:0]  count;
        logic              in_stack;
    } t_entry;

    typedef struct packed {
        logic             rotate;
        logic             append;
        logic             compact;
        logic [CNT_W-1:0] live;
        logic [IDX_W-1:0] pos;
    } t_cell_ctl;
endpackage
`default_nettype wire

### rtl/avitp_cell.sv
// One table slot of the picker: holds an entry, loads from its right neighbor or, on append, the new entry.
// Depends on avitp_pkg.
`default_nettype none
module avitp_cell
    import avitp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry    i_right,
    input  wire t_entry    i_wr,
    output t_entry         o_entry
);
    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_entry <= i_right;
        end else if (i_ctl.append && ({1'b0, i_idx} == i_ctl.live)) begin
            r_entry <= i_wr;
        end else if (i_ctl.compact && (i_idx >= i_ctl.pos)) begin
            r_entry <= i_right;
        end
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

### rtl/available_item_table_picker_core.sv
// Top level of the available item table picker: FSM, scan logic, cell ring.
// Depends on avitp_pkg, avitp_cell and available_item_table_picker_core_defines.svh.
//
// Usage:
//   A request (i_req) is taken at a clock edge with start high and busy low.
//   Exactly one response appears on o_rsp, qualified by o_done for a single
//   cycle; the receiver cannot stall it and must take it then.
//   The table lives in a ring of TABLE_DEPTH cells. Lookups and picks rotate
//   the ring once around, one slot per cycle, inspecting the head cell; the
//   ring is back in place when the scan ends. Decrement and toggle edit
//   the entry as it wraps from head to tail. Delete then shifts every cell at
//   or above the hit one step down, all at the same clock edge.
//   Append and unused op codes finish in S_PREP, which sets o_done; every
//   other op runs S_PREP, the full ring rotation in S_SCAN, then S_DONE.
//   Busy stays high until o_done rises; a new request can be accepted in the
//   same cycle o_done is high.
//   Reset clears the FSM and the live/available counters; table contents are
//   left as they are and only live slots are ever read.
`default_nettype none
`include "available_item_table_picker_core_defines.svh"
module available_item_table_picker_core
    import avitp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_done,
    output t_rsp      o_rsp
);
    typedef enum logic [1:0] {S_IDLE, S_PREP, S_SCAN, S_DONE} t_state;

    t_state            r_state;
    t_req              r_req;
    logic [CNT_W-1:0]  r_live, r_avail, r_k, r_seen;
    logic [REFS_W-1:0] r_t;
    logic [SUM_W-1:0]  r_sum;
    logic [IDX_W-1:0]  r_step, r_pos;
    logic              r_found, r_flag;
    logic [REF_W-1:0]  r_cnt;
    logic [NAME_W-1:0] r_name;
    logic              r_done;
    t_rsp              r_rsp;

    t_entry    w_cell [TABLE_DEPTH];
    t_entry    w_tail, w_head, w_wr;
    t_cell_ctl w_ctl;

    logic                    w_is_live, w_lookup, w_hit, w_cand;
    logic [SUM_W-1:0]        w_sum_next;
    logic [FRAC_W+CNT_W-1:0] w_kprod;
    logic [FRAC_W+REFS_W-1:0] w_tprod;

    assign w_head     = w_cell[0];
    assign w_is_live  = ({1'b0, r_step} < r_live);
    assign w_lookup   = (r_req.op == OP_DEC) || (r_req.op == OP_QUERY) ||
                        (r_req.op == OP_DELETE) || (r_req.op == OP_TOGGLE);
    assign w_hit      = w_lookup && w_is_live && !r_found &&
                        (w_head.name == r_req.item_name);
    assign w_cand     = w_is_live && !r_found && !w_head.in_stack;
    assign w_sum_next = r_sum + SUM_W'(w_head.count);
    assign w_kprod    = (FRAC_W+CNT_W)'(r_req.random_fraction) * (FRAC_W+CNT_W)'(r_avail);
    assign w_tprod    = (FRAC_W+REFS_W)'(r_req.random_fraction) *
                        (FRAC_W+REFS_W)'(r_req.refs_remaining);

    // Entry that wraps into the tail: edited in flight on a hit.
    always_comb begin
        w_tail = w_head;
        if (w_hit && (r_req.op == OP_DEC) && (w_head.count != '0)) begin
            w_tail.count = w_head.count - REF_W'(1);
        end
        if (w_hit && (r_req.op == OP_TOGGLE)) begin
            w_tail.in_stack = !w_head.in_stack;
        end
    end

    assign w_wr = '{name: r_req.item_name, count: r_req.ref_count, in_stack: 1'b0};

    always_comb begin
        w_ctl         = '0;
        w_ctl.live    = r_live;
        w_ctl.pos     = r_pos;
        w_ctl.rotate  = (r_state == S_SCAN);
        w_ctl.append  = (r_state == S_PREP) && (r_req.op == OP_APPEND) &&
                        (r_live != CNT_W'(TABLE_DEPTH));
        w_ctl.compact = (r_state == S_DONE) && (r_req.op == OP_DELETE) && r_found;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        avitp_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_right ((g == TABLE_DEPTH - 1) ? w_tail : w_cell[(g + 1) % TABLE_DEPTH]),
            .i_wr    (w_wr),
            .o_entry (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_avail <= '0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_k     <= w_kprod[FRAC_W +: CNT_W];
                    r_t     <= w_tprod[FRAC_W +: REFS_W];
                    r_step  <= '0;
                    r_seen  <= '0;
                    r_sum   <= '0;
                    r_found <= 1'b0;
                    r_name  <= '0;
                    r_cnt   <= '0;
                    r_flag  <= 1'b0;
                    r_pos   <= '0;
                    if (r_req.op == OP_APPEND) begin
                        r_rsp <= '{status: (r_live == CNT_W'(TABLE_DEPTH)) ? ST_FULL : ST_OK,
                                   picked_name: r_req.item_name, count_out: '0};
                        if (r_live != CNT_W'(TABLE_DEPTH)) begin
                            r_live  <= r_live + CNT_W'(1);
                            r_avail <= r_avail + CNT_W'(1);
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_req.op == OP_UNUSED) begin
                        r_rsp   <= '{status: ST_OK, picked_name: r_req.item_name, count_out: '0};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_done  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_done <= 1'b0;
                    r_step <= r_step + IDX_W'(1);
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_pos   <= r_step;
                        r_cnt   <= w_tail.count;
                        r_flag  <= w_head.in_stack;
                    end
                    if (r_req.op == OP_UNIFORM && w_cand) begin
                        if (r_seen == r_k) begin
                            r_found <= 1'b1;
                            r_name  <= w_head.name;
                        end else begin
                            r_seen <= r_seen + CNT_W'(1);
                        end
                    end
                    if (r_req.op == OP_WEIGHTED && w_cand) begin
                        r_sum <= w_sum_next;
                        if (64'(w_sum_next) > 64'(r_t)) begin
                            r_found <= 1'b1;
                            r_name  <= w_head.name;
                        end
                    end
                    if (r_step == IDX_W'(TABLE_DEPTH - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_req.op == OP_UNIFORM || r_req.op == OP_WEIGHTED) begin
                        if (r_found) begin
                            r_rsp <= '{status: ST_OK, picked_name: r_name, count_out: '0};
                        end else begin
                            r_rsp <= '{status: ST_NO_PICK, picked_name: '0, count_out: '0};
                        end
                    end else begin
                        r_rsp <= '{status: r_found ? ST_OK : ST_NOT_FOUND,
                                   picked_name: r_req.item_name,
                                   count_out: (r_found && (r_req.op == OP_DEC ||
                                               r_req.op == OP_QUERY)) ? r_cnt : '0};
                    end
                    if (r_found && r_req.op == OP_DELETE) begin
                        r_live <= r_live - CNT_W'(1);
                        if (!r_flag && r_avail != '0) begin
                            r_avail <= r_avail - CNT_W'(1);
                        end
                    end
                    if (r_found && r_req.op == OP_TOGGLE) begin
                        if (!r_flag) begin
                            if (r_avail != '0) begin
                                r_avail <= r_avail - CNT_W'(1);
                            end
                        end else begin
                            r_avail <= r_avail + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `AVITP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `AVITP_ASSERT_NEXT(a_done_pulse, o_done, !o_done)
    `AVITP_ASSERT_ALWAYS(a_avail_le_live, r_avail <= r_live)
    `AVITP_ASSERT_ALWAYS(a_live_bound, r_live <= CNT_W'(TABLE_DEPTH))
endmodule
`default_nettype wire
